### src/bcrf_pkg.sv
// Package for the batched-commit ring FIFO: command, status and field-width constants,
// and the command entry type passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcrf_pkg;

	// Field widths fixed by the interface
	localparam int CMD_W    = 3;
	localparam int WORD_W   = 64;
	localparam int MAXC_W   = 7;
	localparam int CNT_W    = 9;
	localparam int STATUS_W = 2;

	// Command codes; unused codes are folded into CMD_NOP by the front end
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEEK  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_NOP   = 3'd7;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLAMPED = 2'd3;

	// Flush threshold after reset
	localparam logic [CNT_W-1:0] THRESH_RESET = 9'd16;

	// Classified request held in the queue between front and back
	typedef struct packed {
		logic [CMD_W-1:0]  kind;
		logic [WORD_W-1:0] write_word;
		logic              end_of_batch;
		logic              flush_now;
		logic [MAXC_W-1:0] burst_lim;
		logic [CNT_W-1:0]  seek_count;
	} cmd_entry_t;

endpackage

`default_nettype wire

### src/bcrf_front.sv
// Front end of the batched-commit ring FIFO: takes requests, classifies them and
// holds them in a two-entry queue for the back end. Uses bcrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcrf_front
	import bcrf_pkg::*;
#(
	parameter int MAX_BURST = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic [WORD_W-1:0] write_word,
	input  wire logic              end_of_batch,
	input  wire logic              flush_now,
	input  wire logic [MAXC_W-1:0] max_count,
	input  wire logic [CNT_W-1:0]  seek_count,
	output logic                   busy,
	output logic                   q_valid,
	output cmd_entry_t             q_entry,
	input  wire logic              q_pop
);

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;
	localparam logic [MAXC_W-1:0] BURST_LIM = MAXC_W'(MAX_BURST);

	cmd_entry_t       entries_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	cmd_entry_t       new_entry;
	logic             push;

	// Classify: fold unused codes, clamp the burst length
	always_comb begin
		new_entry = '0;
		case (cmd)
			CMD_WRITE, CMD_FLUSH, CMD_READ, CMD_PEEK, CMD_SEEK: new_entry.kind = cmd;
			default: new_entry.kind = CMD_NOP;
		endcase
		new_entry.write_word   = write_word;
		new_entry.end_of_batch = end_of_batch;
		new_entry.flush_now    = flush_now;
		new_entry.burst_lim    = (max_count > BURST_LIM) ? BURST_LIM : max_count;
		new_entry.seek_count   = seek_count;
	end

	assign busy    = (count_q == (QAW+1)'(QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign q_entry = entries_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_entry;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/bcrf_back.sv
// Back end of the batched-commit ring FIFO: word store, ring pointers, flush
// threshold and the sequencer that carries out requests. Uses bcrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcrf_back
	import bcrf_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CNT_W-1:0]    cfg_wdata,
	input  wire logic                q_valid,
	input  wire cmd_entry_t          q_entry,
	output logic                     q_pop,
	output logic                     result_valid,
	output logic [STATUS_W-1:0]      status,
	output logic [WORD_W-1:0]        word,
	output logic                     last,
	output logic [CNT_W-1:0]         published_count,
	output logic [CNT_W-1:0]         free_space
);

	localparam int AW   = $clog2(DEPTH);
	localparam int PW   = AW + 1;
	localparam int CMPW = (PW > CNT_W) ? PW : CNT_W;
	localparam logic [PW:0]   RING_X  = (PW+1)'(2 * DEPTH);
	localparam logic [PW:0]   DEPTH_X = (PW+1)'(DEPTH);
	localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_BURST = 1'b1;

	// Distance from behind to ahead, modulo twice the depth
	function automatic logic [PW-1:0] ring_dist(input logic [PW-1:0] ahead,
		input logic [PW-1:0] behind);
		logic [PW:0] d;
		d = {1'b0, ahead} + RING_X - {1'b0, behind};
		if (d >= RING_X) begin
			d = d - RING_X;
		end
		return d[PW-1:0];
	endfunction

	// Pointer advance by at most DEPTH, modulo twice the depth
	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p,
		input logic [PW-1:0] n);
		logic [PW:0] s;
		s = {1'b0, p} + {1'b0, n};
		if (s >= RING_X) begin
			s = s - RING_X;
		end
		return s[PW-1:0];
	endfunction

	// Storage slot of a pointer
	function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
		logic [PW:0] s;
		s = {1'b0, p};
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[AW-1:0];
	endfunction

	logic [WORD_W-1:0] mem [DEPTH];

	logic              state_q;
	logic [PW-1:0]     head_q;
	logic [PW-1:0]     pub_q;
	logic [PW-1:0]     tail_q;
	logic [CNT_W-1:0]  thresh_q;
	logic [PW-1:0]     addr_q;
	logic [MAXC_W-1:0] cnt_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              valid_q;
	logic [STATUS_W-1:0] status_q;
	logic              last_q;
	logic              word_sel_q;

	logic [PW-1:0]     avail;
	logic [PW-1:0]     used;
	logic              full;
	logic [PW-1:0]     tail_inc;
	logic              do_publish;
	logic [MAXC_W-1:0] burst_n;
	logic              seek_over;
	logic              mem_we;

	// Occupancy of the ring as it stands
	assign avail = ring_dist(pub_q, head_q);
	assign used  = ring_dist(tail_q, head_q);
	assign full  = (used >= DEPTH_P);

	// Write path and batch-end publish decision
	always_comb begin
		tail_inc   = full ? tail_q : ptr_add(tail_q, PW'(1));
		do_publish = q_entry.end_of_batch && (q_entry.flush_now ||
			(CMPW'(ring_dist(tail_inc, pub_q)) >= CMPW'(thresh_q)));
	end

	// Burst length and seek clamp
	assign burst_n   = (CMPW'(avail) < CMPW'(q_entry.burst_lim)) ? MAXC_W'(avail)
		: q_entry.burst_lim;
	assign seek_over = (CMPW'(q_entry.seek_count) > CMPW'(avail));

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign mem_we = q_pop && (q_entry.kind == CMD_WRITE) && !full;

	// Word store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_of(tail_q)] <= q_entry.write_word;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BURST) begin
			rd_data_q <= mem[slot_of(addr_q)];
		end
	end

	// Flush threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// Sequencer: one request per cycle while idle; in a burst it reads the words in order and takes no new request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			pub_q      <= '0;
			tail_q     <= '0;
			addr_q     <= '0;
			cnt_q      <= '0;
			valid_q    <= 1'b0;
			status_q   <= ST_OK;
			last_q     <= 1'b0;
			word_sel_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						valid_q    <= 1'b1;
						status_q   <= ST_OK;
						last_q     <= 1'b1;
						word_sel_q <= 1'b0;
						case (q_entry.kind)
							CMD_WRITE: begin
								if (full) begin
									status_q <= ST_FULL;
								end
								tail_q <= tail_inc;
								if (do_publish) begin
									pub_q <= tail_inc;
								end
							end
							CMD_FLUSH: begin
								pub_q <= tail_q;
							end
							CMD_READ, CMD_PEEK: begin
								if (avail == '0) begin
									status_q <= ST_EMPTY;
								end else if (burst_n != '0) begin
									// Burst results come from the sequencer
									valid_q <= 1'b0;
									addr_q  <= head_q;
									cnt_q   <= burst_n;
									state_q <= ST_BURST;
									if (q_entry.kind == CMD_READ) begin
										head_q <= ptr_add(head_q, PW'(burst_n));
									end
								end
							end
							CMD_SEEK: begin
								if (seek_over) begin
									status_q <= ST_CLAMPED;
									head_q   <= pub_q;
								end else begin
									head_q <= ptr_add(head_q, PW'(q_entry.seek_count));
								end
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end
				ST_BURST: begin
					valid_q    <= 1'b1;
					status_q   <= ST_OK;
					word_sel_q <= 1'b1;
					last_q     <= (cnt_q == MAXC_W'(1));
					addr_q     <= ptr_add(addr_q, PW'(1));
					cnt_q      <= cnt_q - 1'b1;
					if (cnt_q == MAXC_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result ports; counts follow the pointers, which hold while a result is shown
	assign result_valid    = valid_q;
	assign status          = status_q;
	assign last            = last_q;
	assign word            = word_sel_q ? rd_data_q : '0;
	assign published_count = CNT_W'(avail);
	assign free_space      = full ? '0 : CNT_W'(DEPTH_P - used);

endmodule

`default_nettype wire

### src/batched_commit_ring_fifo_unit.sv
// Batched-commit ring FIFO, top level: joins the request front end and the back end.
// An accepted request is registered in the front-end queue and reaches the idle back end
// in the next cycle; a one-result request's result is registered as the back end takes it,
// while a read or peek burst enters the burst state and reads its n words in order, one word
// per cycle through the store's single read port. Each other request gives a single result.
// Reset: pointers zero, threshold 16; the word store is not cleared. Results cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module batched_commit_ring_fifo_unit
	import bcrf_pkg::*;
#(
	parameter int DEPTH     = 256,
	parameter int MAX_BURST = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire logic [WORD_W-1:0]   write_word,
	input  wire logic                end_of_batch,
	input  wire logic                flush_now,
	input  wire logic [MAXC_W-1:0]   max_count,
	input  wire logic [CNT_W-1:0]    seek_count,
	input  wire logic                cfg_we,
	input  wire logic [CNT_W-1:0]    cfg_wdata,
	output logic                     result_valid,
	output logic [STATUS_W-1:0]      status,
	output logic [WORD_W-1:0]        word,
	output logic                     last,
	output logic [CNT_W-1:0]         published_count,
	output logic [CNT_W-1:0]         free_space
);

	logic       q_valid;
	logic       q_pop;
	cmd_entry_t q_entry;

	// Request intake and queue
	bcrf_front #(
		.MAX_BURST(MAX_BURST)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.write_word   (write_word),
		.end_of_batch (end_of_batch),
		.flush_now    (flush_now),
		.max_count    (max_count),
		.seek_count   (seek_count),
		.busy         (busy),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop)
	);

	// Execution and storage
	bcrf_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.q_valid         (q_valid),
		.q_entry         (q_entry),
		.q_pop           (q_pop),
		.result_valid    (result_valid),
		.status          (status),
		.word            (word),
		.last            (last),
		.published_count (published_count),
		.free_space      (free_space)
	);

endmodule

`default_nettype wire

### tb/tb_batched_commit_ring_fifo_unit.sv
// Testbench for the batched-commit ring FIFO: directed table, then randomized
// write batches, bursts, seeks and flushes checked against a local predictor.
// Depends on bcrf_pkg and batched_commit_ring_fifo_unit.
`timescale 1ns / 1ps

module tb_batched_commit_ring_fifo_unit;
	import bcrf_pkg::*;

	localparam int FIFO_DEPTH    = 256;
	localparam int BURST_MAX     = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 32;

	// Command codes the block leaves unused
	localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;

	// Threshold and sender idle percentage of each random phase
	localparam logic [CNT_W-1:0] PHASE_THRESH [6] = '{9'd1, 9'd0, 9'd511, 9'd5, 9'd256, 9'd16};
	localparam int PHASE_IDLE [6] = '{34, 34, 61, 61, 0, 0};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   word;
		logic                last;
		logic [CNT_W-1:0]    published;
		logic [CNT_W-1:0]    free_slots;
	} fifo_result_t;

	// One directed request; typed rows carry their own expected single result
	typedef struct packed {
		logic [CMD_W-1:0]    op;
		logic [WORD_W-1:0]   data;
		logic                eob;
		logic                frc;
		logic [MAXC_W-1:0]   burst;
		logic [CNT_W-1:0]    skip;
		logic                typed;
		logic [STATUS_W-1:0] t_status;
		logic [CNT_W-1:0]    t_published;
		logic [CNT_W-1:0]    t_free;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [19] = '{
		'{CMD_READ,   64'h0,                  1'b0, 1'b0, 7'd4,   9'd0,   1'b1, ST_EMPTY,   9'd0, 9'd256},
		'{CMD_PEEK,   64'h0,                  1'b0, 1'b0, 7'd64,  9'd0,   1'b1, ST_EMPTY,   9'd0, 9'd256},
		'{CMD_SEEK,   64'h0,                  1'b0, 1'b0, 7'd0,   9'd5,   1'b1, ST_CLAMPED, 9'd0, 9'd256},
		'{CMD_WRITE,  64'h0,                  1'b0, 1'b0, 7'd0,   9'd0,   1'b1, ST_OK,      9'd0, 9'd255},
		'{CMD_WRITE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 7'd127, 9'd511, 1'b1, ST_OK,      9'd0, 9'd254},
		'{CMD_FLUSH,  64'h0,                  1'b0, 1'b0, 7'd0,   9'd0,   1'b1, ST_OK,      9'd2, 9'd254},
		'{CMD_READ,   64'h0,                  1'b0, 1'b0, 7'd0,   9'd0,   1'b1, ST_OK,      9'd2, 9'd254},
		'{CMD_PEEK,   64'h0,                  1'b0, 1'b0, 7'd127, 9'd0,   1'b0, ST_OK,      9'd0, 9'd0},
		'{CMD_WRITE,  64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 1'b1, 7'd0,   9'd0,   1'b1, ST_OK,      9'd3, 9'd253},
		'{CMD_SPARE5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 7'd127, 9'd511, 1'b1, ST_OK,      9'd3, 9'd253},
		'{CMD_SPARE6, 64'h0,                  1'b0, 1'b0, 7'd0,   9'd0,   1'b1, ST_OK,      9'd3, 9'd253},
		'{CMD_NOP,    64'h0,                  1'b1, 1'b0, 7'd64,  9'd256, 1'b1, ST_OK,      9'd3, 9'd253},
		'{CMD_SEEK,   64'h0,                  1'b0, 1'b0, 7'd0,   9'd1,   1'b1, ST_OK,      9'd2, 9'd254},
		'{CMD_READ,   64'h0,                  1'b0, 1'b0, 7'd127, 9'd0,   1'b0, ST_OK,      9'd0, 9'd0},
		'{CMD_SEEK,   64'h0,                  1'b0, 1'b0, 7'd0,   9'd0,   1'b1, ST_OK,      9'd0, 9'd256},
		'{CMD_SEEK,   64'h0,                  1'b0, 1'b0, 7'd0,   9'd511, 1'b1, ST_CLAMPED, 9'd0, 9'd256},
		'{CMD_WRITE,  64'h8000_0000_0000_0001, 1'b1, 1'b0, 7'd0,   9'd0,   1'b1, ST_OK,      9'd0, 9'd255},
		'{CMD_FLUSH,  64'h0,                  1'b0, 1'b0, 7'd0,   9'd0,   1'b1, ST_OK,      9'd1, 9'd255},
		'{CMD_READ,   64'h0,                  1'b0, 1'b0, 7'd1,   9'd0,   1'b0, ST_OK,      9'd0, 9'd0}
	};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    cmd;
	logic [WORD_W-1:0]   write_word;
	logic                end_of_batch;
	logic                flush_now;
	logic [MAXC_W-1:0]   max_count;
	logic [CNT_W-1:0]    seek_count;
	logic                cfg_we;
	logic [CNT_W-1:0]    cfg_wdata;
	logic                result_valid;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   word;
	logic                last;
	logic [CNT_W-1:0]    published_count;
	logic [CNT_W-1:0]    free_space;

	// Predictor state: mirror of the ring and its three pointers
	logic [WORD_W-1:0] mirror_store [FIFO_DEPTH];
	logic [CNT_W-1:0]  head_ptr;
	logic [CNT_W-1:0]  publish_ptr;
	logic [CNT_W-1:0]  tail_ptr;
	logic [CNT_W-1:0]  threshold_reg;

	fifo_result_t pending_results [$];
	int           mismatch_count;
	int           idle_pct;
	int           stall_cycles;

	batched_commit_ring_fifo_unit #(
		.DEPTH(FIFO_DEPTH),
		.MAX_BURST(BURST_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.write_word(write_word),
		.end_of_batch(end_of_batch),
		.flush_now(flush_now),
		.max_count(max_count),
		.seek_count(seek_count),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.status(status),
		.word(word),
		.last(last),
		.published_count(published_count),
		.free_space(free_space)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Pointer distance modulo twice the depth
	function automatic logic [CNT_W-1:0] ring_gap(input logic [CNT_W-1:0] ahead,
		input logic [CNT_W-1:0] behind);
		return ahead - behind;
	endfunction

	task automatic push_result(input logic [STATUS_W-1:0] st, input logic [WORD_W-1:0] w,
		input logic l);
		fifo_result_t r;
		logic [CNT_W-1:0] used;
		used = ring_gap(tail_ptr, head_ptr);
		r.status     = st;
		r.word       = w;
		r.last       = l;
		r.published  = ring_gap(publish_ptr, head_ptr);
		r.free_slots = (used >= FIFO_DEPTH) ? '0 : CNT_W'(FIFO_DEPTH - used);
		pending_results.push_back(r);
	endtask

	// Expected results of one accepted request; updates the mirrored ring
	task automatic predict_fifo_results(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] w,
		input logic e, input logic f, input logic [MAXC_W-1:0] m, input logic [CNT_W-1:0] s);
		logic [CNT_W-1:0]    avail;
		logic [CNT_W-1:0]    lim;
		logic [CNT_W-1:0]    n;
		logic [CNT_W-1:0]    first;
		logic [CNT_W-1:0]    slot;
		logic [CNT_W-1:0]    skip;
		logic [STATUS_W-1:0] st;
		st = ST_OK;
		case (c)
		CMD_WRITE: begin
			if (ring_gap(tail_ptr, head_ptr) >= FIFO_DEPTH) begin
				st = ST_FULL;
			end else begin
				mirror_store[tail_ptr[7:0]] = w;
				tail_ptr = tail_ptr + 1'b1;
			end
			// batch-end publish check runs even after a rejected write
			if (e && (f || ring_gap(tail_ptr, publish_ptr) >= threshold_reg))
				publish_ptr = tail_ptr;
			push_result(st, '0, 1'b1);
		end
		CMD_FLUSH: begin
			publish_ptr = tail_ptr;
			push_result(ST_OK, '0, 1'b1);
		end
		CMD_READ, CMD_PEEK: begin
			avail = ring_gap(publish_ptr, head_ptr);
			lim   = (m > BURST_MAX) ? CNT_W'(BURST_MAX) : CNT_W'(m);
			n     = (avail > lim) ? lim : avail;
			first = head_ptr;
			if (avail == 0) begin
				push_result(ST_EMPTY, '0, 1'b1);
			end else if (n == 0) begin
				push_result(ST_OK, '0, 1'b1);
			end else begin
				if (c == CMD_READ)
					head_ptr = head_ptr + n;
				for (int i = 0; i < n; i++) begin
					slot = first + CNT_W'(i);
					push_result(ST_OK, mirror_store[slot[7:0]], (i + 1 == n));
				end
			end
		end
		CMD_SEEK: begin
			avail = ring_gap(publish_ptr, head_ptr);
			skip  = s;
			if (skip > avail) begin
				skip = avail;
				st   = ST_CLAMPED;
			end
			head_ptr = head_ptr + skip;
			push_result(st, '0, 1'b1);
		end
		default: push_result(ST_OK, '0, 1'b1);
		endcase
	endtask

	// Present one request, with a random gap first, and predict it once accepted
	task automatic send_request(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] w,
		input logic e, input logic f, input logic [MAXC_W-1:0] m, input logic [CNT_W-1:0] s);
		if ($urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(1, 100) <= idle_pct);
		end
		start        <= 1'b1;
		cmd          <= c;
		write_word   <= w;
		end_of_batch <= e;
		flush_now    <= f;
		max_count    <= m;
		seek_count   <= s;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_fifo_results(c, w, e, f, m, s);
	endtask

	// Stop sending and let every expected result come out
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [CNT_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we        <= 1'b0;
		threshold_reg = value;
	endtask

	// Mostly well-formed write batches and bursts, some random noise
	task automatic send_traffic_mix(input int quota);
		int sent;
		int pick;
		int len;
		logic [CMD_W-1:0]  c;
		logic [WORD_W-1:0] w;
		logic              e;
		logic              f;
		logic [MAXC_W-1:0] m;
		logic [CNT_W-1:0]  s;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			w = {$urandom, $urandom};
			e = 1'($urandom_range(0, 1));
			f = 1'($urandom_range(0, 1));
			m = MAXC_W'($urandom_range(0, 127));
			s = CNT_W'($urandom_range(0, 511));
			if (pick < 45) begin
				len = $urandom_range(1, 10);
				for (int j = 0; j < len; j++) begin
					w = {$urandom, $urandom};
					m = MAXC_W'($urandom_range(0, 127));
					s = CNT_W'($urandom_range(0, 511));
					send_request(CMD_WRITE, w, (j == len - 1), ($urandom_range(0, 3) == 0), m, s);
				end
				sent += len;
			end else begin
				if (pick < 73) begin
					c = (pick < 63) ? CMD_READ : CMD_PEEK;
					if ($urandom_range(0, 3) != 0)
						m = MAXC_W'($urandom_range(1, 12));
				end else if (pick < 82) begin
					c = CMD_SEEK;
					if ($urandom_range(0, 3) != 0)
						s = CNT_W'($urandom_range(0, 8));
				end else if (pick < 88) begin
					c = CMD_FLUSH;
				end else begin
					c = CMD_W'($urandom_range(0, 7));
				end
				send_request(c, w, e, f, m, s);
				sent++;
			end
		end
	endtask

	// Result checker: every strobed result against the oldest expectation
	always @(posedge clk) begin : result_check
		fifo_result_t exp_r;
		if (arst_n && result_valid === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status)
					report_mismatch($sformatf("status got %0d expected %0d", status, exp_r.status));
				if (word !== exp_r.word)
					report_mismatch($sformatf("word got %h expected %h", word, exp_r.word));
				if (last !== exp_r.last)
					report_mismatch($sformatf("last got %0b expected %0b", last, exp_r.last));
				if (published_count !== exp_r.published)
					report_mismatch($sformatf("published_count got %0d expected %0d",
						published_count, exp_r.published));
				if (free_space !== exp_r.free_slots)
					report_mismatch($sformatf("free_space got %0d expected %0d",
						free_space, exp_r.free_slots));
			end
		end
	end

	// Watchdog: too long without an accepted request or a result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && busy === 1'b0) || result_valid === 1'b1)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		fifo_result_t typed_r;
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = CMD_WRITE;
		write_word     = '0;
		end_of_batch   = 1'b0;
		flush_now      = 1'b0;
		max_count      = '0;
		seek_count     = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		mismatch_count = 0;
		stall_cycles   = 0;
		idle_pct       = 34;
		head_ptr       = '0;
		publish_ptr    = '0;
		tail_ptr       = '0;
		threshold_reg  = THRESH_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset threshold
		foreach (DIRECTED_ROWS[i]) begin
			send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].eob,
				DIRECTED_ROWS[i].frc, DIRECTED_ROWS[i].burst, DIRECTED_ROWS[i].skip);
			if (DIRECTED_ROWS[i].typed) begin
				void'(pending_results.pop_back());
				typed_r = '{DIRECTED_ROWS[i].t_status, '0, 1'b1,
					DIRECTED_ROWS[i].t_published, DIRECTED_ROWS[i].t_free};
				pending_results.push_back(typed_r);
			end
		end

		// Random phases over several thresholds and sender idle rates
		for (int p = 0; p < 6; p++) begin
			set_threshold(PHASE_THRESH[p]);
			idle_pct = PHASE_IDLE[p];
			send_traffic_mix(PHASE_ITEMS);
		end

		drain_results();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
